// ----- rtl/nearest_point_classifier_top_defines.svh -----
// assertion macros for the nearest point classifier checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef NEAREST_POINT_CLASSIFIER_TOP_DEFINES_SVH
`define NEAREST_POINT_CLASSIFIER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NPC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("npc check failed");

// consequent must hold in the cycle after the antecedent
`define NPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("npc check failed");

`endif

// ----- rtl/npc_pkg.sv -----
// shared types and constants of the nearest point classifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

  // field widths
  localparam int unsigned HeatW   = 24;
  localparam int unsigned HeightW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned DistW   = 51;

  localparam int unsigned TableDepthDef = 64;

  // request codes
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // configuration register indexes
  localparam logic CfgHeatOffset = 1'b0;
  localparam logic CfgHeatGain   = 1'b1;

  localparam logic signed [GainW-1:0] HeatGainRst = 16'sd256;

  // 50.0 in Q16.8
  localparam logic signed [HeatW:0] FiftyQ8 = 25'sd12800;

  // saturation bounds of a 24 bit heat value
  localparam logic signed [HeatW+9:0] HeatSatHi = 34'sd8388607;
  localparam logic signed [HeatW+9:0] HeatSatLo = -34'sd8388608;

  typedef struct packed {
    logic                      req_type;
    logic [IdxW-1:0]           entry_index;
    logic                      entry_valid;
    logic signed [HeightW-1:0] entry_height_min;
    logic signed [HeightW-1:0] entry_height_max;
    logic signed [HeatW-1:0]   entry_heat_point;
    logic signed [HeatW-1:0]   entry_humidity_point;
    logic signed [HeatW-1:0]   query_heat;
    logic signed [HeatW-1:0]   query_humidity;
    logic signed [HeightW-1:0] query_height;
  } npc_req_t;

  typedef struct packed {
    logic [IdxW-1:0] class_index;
    logic            fell_back;
  } npc_res_t;

  // one stored table entry, present bit kept apart
  typedef struct packed {
    logic signed [HeightW-1:0] height_min;
    logic signed [HeightW-1:0] height_max;
    logic signed [HeatW-1:0]   heat_ref;
    logic signed [HeatW-1:0]   humidity_ref;
  } npc_entry_t;

  // control word that travels with each entry down the scan pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic qual;
  } npc_tag_t;

endpackage

`default_nettype wire

// ----- rtl/npc_table.sv -----
// class entry table: entry memory plus present flags cleared at reset
// depends on npc_pkg
`timescale 1ns / 1ps
`default_nettype none

module npc_table
  import npc_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(TableDepth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic             wr_present_i,
  input  wire npc_entry_t       wr_entry_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic                  rd_present_o,
  output npc_entry_t            rd_entry_o
);

  npc_entry_t             mem_q [TableDepth];
  logic [TableDepth-1:0]  present_q;
  logic                   rd_present_q;
  npc_entry_t             rd_entry_q;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  // present flags, all clear after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        present_q[wr_addr_i] <= wr_present_i;
      end
      if (rd_en_i) begin
        rd_present_q <= present_q[rd_addr_i];
      end
    end
  end

  assign rd_present_o = rd_present_q;
  assign rd_entry_o   = rd_entry_q;

endmodule

`default_nettype wire

// ----- rtl/npc_dist.sv -----
// shared distance unit: window check, heat remap and squared distance
// five register stages, one entry per cycle; depends on npc_pkg
`timescale 1ns / 1ps
`default_nettype none

module npc_dist
  import npc_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(TableDepth)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire npc_tag_t                  tag_i,
  input  wire logic [AddrW-1:0]          idx_i,
  input  wire logic                      present_i,
  input  wire npc_entry_t                entry_i,
  input  wire logic signed [HeatW-1:0]   query_heat_i,
  input  wire logic signed [HeatW-1:0]   query_humidity_i,
  input  wire logic signed [HeightW-1:0] query_height_i,
  input  wire logic signed [HeatW-1:0]   heat_offset_i,
  input  wire logic signed [GainW-1:0]   heat_gain_i,
  output npc_tag_t                       tag_o,
  output logic [AddrW-1:0]               idx_o,
  output logic [DistW-1:0]               dist_o
);

  logic signed [HeightW-1:0] y, hmin, hmax;
  logic signed [HeatW:0]     heat_ofs;
  logic signed [40:0]        prod_d;
  logic                      qual;

  npc_tag_t                  a_tag_q, b_tag_q, c_tag_q, d_tag_q, e_tag_q;
  logic [AddrW-1:0]          a_idx_q, b_idx_q, c_idx_q, d_idx_q, e_idx_q;
  logic signed [40:0]        prod_q;
  logic signed [HeatW-1:0]   a_hum_q;

  logic signed [40:0]        rnd_ext;
  logic signed [32:0]        rnd;
  logic signed [HeatW+9:0]   rnd_x, ofs_x, sum;
  logic signed [HeatW-1:0]   hp_d, hp_q;
  logic signed [HeatW:0]     dhum_d, b_dhum_q;

  logic signed [HeatW:0]     dheat_d, dheat_q, c_dhum_q;
  logic signed [2*HeatW+1:0] sqh_d, sqm_d;
  logic [2*HeatW+1:0]        sqh_q, sqm_q;
  logic [DistW-1:0]          dist_q;

  // stage a: height window check and heat times gain
  assign y        = query_height_i;
  assign hmin     = entry_i.height_min;
  assign hmax     = entry_i.height_max;
  assign qual     = present_i && !(y > hmax) && !(y < hmin);
  assign heat_ofs = {entry_i.heat_ref[HeatW-1], entry_i.heat_ref} - FiftyQ8;
  assign prod_d   = heat_ofs * heat_gain_i;

  // stage b: round half up to Q16.8, add offset, saturate; humidity difference
  assign rnd_ext = prod_q + 41'sd128;
  assign rnd     = rnd_ext[40:8];
  assign rnd_x   = {rnd[32], rnd};
  assign ofs_x   = {{10{heat_offset_i[HeatW-1]}}, heat_offset_i};
  assign sum     = rnd_x + ofs_x;
  always_comb begin
    if (sum > HeatSatHi) begin
      hp_d = HeatSatHi[HeatW-1:0];
    end else if (sum < HeatSatLo) begin
      hp_d = HeatSatLo[HeatW-1:0];
    end else begin
      hp_d = sum[HeatW-1:0];
    end
  end
  assign dhum_d = {query_humidity_i[HeatW-1], query_humidity_i} - {a_hum_q[HeatW-1], a_hum_q};

  // stage c: heat difference
  assign dheat_d = {query_heat_i[HeatW-1], query_heat_i} - {hp_q[HeatW-1], hp_q};

  // stage d: squares
  assign sqh_d = dheat_q * dheat_q;
  assign sqm_d = c_dhum_q * c_dhum_q;

  // pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_tag_q <= '0;
      b_tag_q <= '0;
      c_tag_q <= '0;
      d_tag_q <= '0;
      e_tag_q <= '0;
    end else begin
      a_tag_q <= '{valid: tag_i.valid, last: tag_i.last, qual: qual};
      b_tag_q <= a_tag_q;
      c_tag_q <= b_tag_q;
      d_tag_q <= c_tag_q;
      e_tag_q <= d_tag_q;
    end
  end

  // pipeline data
  always_ff @(posedge clk_i) begin
    a_idx_q  <= idx_i;
    prod_q   <= prod_d;
    a_hum_q  <= entry_i.humidity_ref;
    b_idx_q  <= a_idx_q;
    hp_q     <= hp_d;
    b_dhum_q <= dhum_d;
    c_idx_q  <= b_idx_q;
    dheat_q  <= dheat_d;
    c_dhum_q <= b_dhum_q;
    d_idx_q  <= c_idx_q;
    sqh_q    <= sqh_d;
    sqm_q    <= sqm_d;
    e_idx_q  <= d_idx_q;
    dist_q   <= {1'b0, sqh_q} + {1'b0, sqm_q};
  end

  assign tag_o  = e_tag_q;
  assign idx_o  = e_idx_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// ----- rtl/npc_seq.sv -----
// scan sequencer: walks the table, keeps the running best, emits the result
// depends on npc_pkg
`timescale 1ns / 1ps
`default_nettype none

module npc_seq
  import npc_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(TableDepth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             query_start_i,
  output logic                  busy_o,
  output logic                  rd_en_o,
  output logic [AddrW-1:0]      rd_addr_o,
  output npc_tag_t              tag_o,
  output logic [AddrW-1:0]      idx_o,
  input  wire npc_tag_t         dist_tag_i,
  input  wire logic [AddrW-1:0] dist_idx_i,
  input  wire logic [DistW-1:0] dist_i,
  output logic                  done_o,
  output npc_res_t              res_o
);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SScan  = 2'd1;
  localparam logic [1:0] SDrain = 2'd2;

  localparam logic [AddrW-1:0] FirstIdx = AddrW'(1);
  localparam logic [AddrW-1:0] LastIdx  = AddrW'(TableDepth - 1);

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  npc_tag_t         tag_q;
  logic [AddrW-1:0] idx_q;
  logic             found_q, found_d;
  logic [AddrW-1:0] best_q, best_d;
  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic             take, finish;
  logic             done_q;
  npc_res_t         res_q, res_d;

  // running minimum, strict less-than keeps the lower index
  assign take   = dist_tag_i.valid && dist_tag_i.qual && (!found_q || dist_i < best_dist_q);
  assign finish = dist_tag_i.valid && dist_tag_i.last;

  always_comb begin
    found_d     = found_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    if (take) begin
      found_d     = 1'b1;
      best_d      = dist_idx_i;
      best_dist_d = dist_i;
    end
    res_d.fell_back   = !found_d;
    res_d.class_index = found_d ? IdxW'(best_d) : '0;
  end

  // state machine
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      SIdle: begin
        if (query_start_i) begin
          state_d = SScan;
          cnt_d   = FirstIdx;
        end
      end
      SScan: begin
        cnt_d = cnt_q + AddrW'(1);
        if (cnt_q == LastIdx) begin
          state_d = SDrain;
        end
      end
      SDrain: begin
        if (finish) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      tag_q   <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tag_q   <= '{valid: (state_q == SScan), last: (cnt_q == LastIdx), qual: 1'b0};
      found_q <= (query_start_i && state_q == SIdle) ? 1'b0 : found_d;
      done_q  <= finish;
    end
  end

  // best entry and result word
  always_ff @(posedge clk_i) begin
    idx_q       <= cnt_q;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign busy_o    = (state_q != SIdle);
  assign rd_en_o   = (state_q == SScan);
  assign rd_addr_o = cnt_q;
  assign tag_o     = tag_q;
  assign idx_o     = idx_q;
  assign done_o    = done_q;
  assign res_o     = res_q;

endmodule

`default_nettype wire

// ----- rtl/nearest_point_classifier_top.sv -----
// top level of the nearest point classifier: ports, registers, query latch
// depends on npc_pkg, npc_table, npc_dist, npc_seq
//
//   channel   | handshake               | word
//   ----------+-------------------------+----------------------------
//   request   | start, busy             | req_i (npc_req_t)
//   result    | done_o strobe, 1 cycle  | res_o (npc_res_t)
//   config    | cfg_we_i, cfg_idx_i     | cfg_data_i (24 bits)
//
// a write word leaves busy low
// a query word holds busy through the scan: one table read per
// cycle for entries 1 to TABLE_DEPTH-1 through the single read port, then
// the five stage distance unit drains; done_o follows in the next cycle
// the receiver cannot stall; done_o marks each result for one cycle and res_o holds it until the next result
// reset at once clears the present flags and control state and loads the configuration reset values
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_classifier_top
  import npc_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  localparam int unsigned AddrW = $clog2(TableDepth)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire npc_req_t         req_i,
  output logic                  done_o,
  output npc_res_t              res_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [HeatW-1:0] cfg_data_i
);

  logic                      accept, wr_in_range, wr_en, query_start;
  logic signed [HeatW-1:0]   heat_offset_q;
  logic signed [GainW-1:0]   heat_gain_q;
  logic signed [HeatW-1:0]   qheat_q, qhum_q;
  logic signed [HeightW-1:0] qheight_q;
  npc_entry_t                wr_entry;
  logic                      rd_en;
  logic [AddrW-1:0]          rd_addr;
  logic                      rd_present;
  npc_entry_t                rd_entry;
  npc_tag_t                  scan_tag, dist_tag;
  logic [AddrW-1:0]          scan_idx, dist_idx;
  logic [DistW-1:0]          scan_dist;

  assign accept      = start && !busy;
  assign wr_in_range = (32'(req_i.entry_index) < 32'(TableDepth));
  assign wr_en       = accept && (req_i.req_type == ReqWrite) && wr_in_range;
  assign query_start = accept && (req_i.req_type == ReqQuery);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_offset_q <= '0;
      heat_gain_q   <= HeatGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeatOffset: heat_offset_q <= cfg_data_i;
        CfgHeatGain:   heat_gain_q   <= cfg_data_i[GainW-1:0];
        default:       heat_gain_q   <= heat_gain_q;
      endcase
    end
  end

  // query point held for the whole scan
  always_ff @(posedge clk_i) begin
    if (query_start) begin
      qheat_q   <= req_i.query_heat;
      qhum_q    <= req_i.query_humidity;
      qheight_q <= req_i.query_height;
    end
  end

  assign wr_entry = '{height_min:   req_i.entry_height_min,
                      height_max:   req_i.entry_height_max,
                      heat_ref:     req_i.entry_heat_point,
                      humidity_ref: req_i.entry_humidity_point};

  npc_table #(.TableDepth(TableDepth)) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (AddrW'(req_i.entry_index)),
    .wr_present_i (req_i.entry_valid),
    .wr_entry_i   (wr_entry),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_present_o (rd_present),
    .rd_entry_o   (rd_entry)
  );

  npc_dist #(.TableDepth(TableDepth)) u_dist (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .tag_i            (scan_tag),
    .idx_i            (scan_idx),
    .present_i        (rd_present),
    .entry_i          (rd_entry),
    .query_heat_i     (qheat_q),
    .query_humidity_i (qhum_q),
    .query_height_i   (qheight_q),
    .heat_offset_i    (heat_offset_q),
    .heat_gain_i      (heat_gain_q),
    .tag_o            (dist_tag),
    .idx_o            (dist_idx),
    .dist_o           (scan_dist)
  );

  npc_seq #(.TableDepth(TableDepth)) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .query_start_i (query_start),
    .busy_o        (busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .tag_o         (scan_tag),
    .idx_o         (scan_idx),
    .dist_tag_i    (dist_tag),
    .dist_idx_i    (dist_idx),
    .dist_i        (scan_dist),
    .done_o        (done_o),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

// ----- rtl/npc_checker.sv -----
// port level checks of the nearest point classifier, bound to the top level
// depends on npc_pkg and nearest_point_classifier_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_point_classifier_top_defines.svh"

module npc_checker
  import npc_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire npc_req_t req_i,
  input wire logic     done_o,
  input wire npc_res_t res_o
);

  // a query word starts a scan
  `NPC_ASSERT_NEXT(a_query_busy, start && !busy && req_i.req_type == ReqQuery, busy)

  // a result only closes a scan
  `NPC_ASSERT_SAME(a_done_after_busy, done_o, $past(busy))

  // one strobe per query
  `NPC_ASSERT_NEXT(a_done_single, done_o, !done_o)

  // the fallback word names entry zero
  `NPC_ASSERT_SAME(a_fallback_zero, done_o && res_o.fell_back, res_o.class_index == '0)

endmodule

bind nearest_point_classifier_top npc_checker u_npc_checker (.*);

`default_nettype wire
